/* hw/rtl/pdc_pkg.sv */
// ----------------------------------------------------------------------------
// pdc_pkg: shared types and constants of the PID controller
// Word layouts, register indexes, controller states and the widths of the
// serial multiply and divide units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdc_pkg;

  // Field widths of the data words.
  localparam int DATA_W = 32;
  localparam int MS_W = 16;
  localparam int BAND_W = 31;
  localparam int FRAC_W = 16;
  localparam int CFG_IDX_W = 3;

  // Error difference and sum carry one extra bit.
  localparam int DIFF_W = DATA_W + 1;
  // Error difference scaled by 1000 (ten bits of constant).
  localparam int SCALE_K_W = 10;
  localparam int SCALED_W = DIFF_W + SCALE_K_W;

  // Serial multiplier: multiplicand up to the rate magnitude, one
  // multiplier bit retired per cycle.
  localparam int MUL_A_W = 42;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // Serial restoring divider: one quotient bit per cycle.
  localparam int DIV_N_W = 48;
  localparam int DIV_D_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  // A signed product shifted down by the fraction bits, and the sum of three.
  localparam int TERM_W = MUL_P_W + 1 - FRAC_W;
  localparam int SUM_W = TERM_W + 2;

  localparam logic [SCALE_K_W-1:0] MS_PER_S = 10'd1000;
  localparam logic [DIV_D_W-1:0] TRAP_DIV = 16'd2000;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P       = 3'd0,
    CFG_GAIN_I       = 3'd1,
    CFG_GAIN_D       = 3'd2,
    CFG_DEAD_BAND    = 3'd3,
    CFG_INTEGRAL_MIN = 3'd4,
    CFG_INTEGRAL_MAX = 3'd5,
    CFG_DRIVE_MIN    = 3'd6,
    CFG_DRIVE_MAX    = 3'd7
  } cfg_sel_t;

  typedef struct packed {
    op_t                       operation;
    logic signed [DATA_W-1:0]  measurement;
    logic signed [DATA_W-1:0]  target;
    logic [MS_W-1:0]           elapsed_ms;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  drive;
    logic                      active;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_BAND,
    ST_DIFF,
    ST_ABS,
    ST_SCALE,
    ST_GO1,
    ST_WAIT1,
    ST_GO2,
    ST_WAIT2,
    ST_ACC,
    ST_ACCSUM,
    ST_CLAMPI,
    ST_GO3,
    ST_WAIT3,
    ST_TERMS,
    ST_SUM1,
    ST_SUM2,
    ST_CLAMPD,
    ST_DONE
  } state_t;

endpackage

/* hw/rtl/pid_deadband_clamped.sv */
// ----------------------------------------------------------------------------
// pid_deadband_clamped: PID controller with dead band and anti-windup clamps
// Signed Q16.16 PID drive from a measurement, a setpoint and the elapsed
// milliseconds, with a trapezoid integral clamped to its bounds and a
// clamped output. Built on one serial divider and two serial multipliers.
//
//   channel  direction  handshake              word
//   in       input      in_valid / in_ready    in_word (operation, measurement,
//                                              target, elapsed_ms)
//   out      output     out_valid / out_ready  out_word (drive, active)
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A computed sample holds the block between acceptances for two 48-step divider
// passes and one 32-step multiplier pass, plus fixed setup and summing states.
// A sample in the dead band or without history skips from the band test to the
// final state, a clear from preparation. One sample is worked on at a time;
// the result register lets the next word in while the result waits. A result
// that is not taken stalls only the final state. Reset (rst_n low, synchronous)
// loads the register defaults and clears the controller history.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_deadband_clamped (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pdc_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pdc_pkg::out_word_t              out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pdc_pkg::DATA_W-1:0]      cfg_data
);
  import pdc_pkg::*;

  // Magnitude of a 32-bit signed value.
  function automatic logic [DATA_W-1:0] abs32(input logic signed [DATA_W-1:0] x);
    return x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
  endfunction

  // Magnitude of a 33-bit signed value.
  function automatic logic [DIFF_W-1:0] abs33(input logic signed [DIFF_W-1:0] x);
    return x[DIFF_W-1] ? (~x + DIFF_W'(1)) : x;
  endfunction

  // Apply the sign to a product magnitude and floor it by the fraction bits.
  function automatic logic signed [TERM_W-1:0] to_term(input logic [MUL_P_W-1:0] mag,
                                                      input logic neg);
    logic [MUL_P_W:0] v;
    v = {1'b0, mag};
    if (neg) begin
      v = ~v + {{MUL_P_W{1'b0}}, 1'b1};
    end
    return v[MUL_P_W:FRAC_W];
  endfunction

  // Clamp; with inverted bounds, values below lo give lo and all others give hi.
  function automatic logic signed [DATA_W-1:0] clamp_w(input logic signed [SUM_W-1:0] v,
                                                      input logic signed [DATA_W-1:0] lo,
                                                      input logic signed [DATA_W-1:0] hi);
    logic signed [SUM_W-1:0] lo_w;
    logic signed [SUM_W-1:0] hi_w;
    logic signed [DATA_W-1:0] r;
    lo_w = SUM_W'(lo);
    hi_w = SUM_W'(hi);
    priority if (v < lo_w) begin
      r = lo;
    end else if (v > hi_w) begin
      r = hi;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Configuration registers.
  logic signed [DATA_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic [BAND_W-1:0]        dead_band_r;
  logic signed [DATA_W-1:0] imin_r, imax_r, dmin_r, dmax_r;

  // Controller history.
  logic                     hist_r;
  logic signed [DATA_W-1:0] pde_r, pse_r, integral_r;

  // Working registers of one sample.
  state_t                   state_r, state_nxt;
  in_word_t                 in_r;
  logic signed [DIFF_W-1:0] raw_r, diff_r, sum_r;
  logic signed [DATA_W-1:0] err_r;
  logic [DIFF_W-1:0]        dmag_r, smag_r;
  logic                     dneg_r, sneg_r, eneg_r;
  logic [DATA_W-1:0]        emag_r;
  logic [DIV_N_W-1:0]       dvd_r;
  logic [MUL_A_W-1:0]       rmag_r;
  logic signed [TERM_W-1:0] p_r, d_r, i_r;
  logic signed [SUM_W-1:0]  inc_r, inc_nxt, acc_r, s_r;
  logic signed [DATA_W-1:0] res_drive_r;
  logic                     res_active_r;
  out_word_t                out_r;
  logic                     out_valid_r;

  // Combinational helpers.
  logic [MS_W-1:0]          ms_eff;
  logic signed [DATA_W-1:0] err_sat;
  logic                     band_out;
  logic [SCALED_W-1:0]      scaled;
  logic [SUM_W-1:0]         quo_w;
  logic                     load_out;

  // Serial unit connections.
  logic                     div_start, div_busy;
  logic [DIV_N_W-1:0]       div_dvd, div_quo;
  logic [DIV_D_W-1:0]       div_den;
  logic                     mula_start, mula_busy;
  logic [MUL_A_W-1:0]       mula_a;
  logic [MUL_B_W-1:0]       mula_b;
  logic [MUL_P_W-1:0]       mula_prod;
  logic                     mulb_start, mulb_busy;
  logic [MUL_A_W-1:0]       mulb_a;
  logic [MUL_B_W-1:0]       mulb_b;
  logic [MUL_P_W-1:0]       mulb_prod;

  // A zero elapsed time counts as one millisecond.
  assign ms_eff = (in_r.elapsed_ms == '0) ? MS_W'(1) : in_r.elapsed_ms;

  // Saturated error and the dead band test on the unsaturated difference.
  assign err_sat = (raw_r[DIFF_W-1] != raw_r[DATA_W-1])
                   ? (raw_r[DIFF_W-1] ? DATA_MIN : DATA_MAX)
                   : raw_r[DATA_W-1:0];
  assign band_out = hist_r && (abs33(raw_r) > {2'b00, dead_band_r});

  // Error change times 1000 for the rate division.
  assign scaled = dmag_r * MS_PER_S;

  // Signed integral increment from the trapezoid quotient.
  assign quo_w = SUM_W'(div_quo);
  assign inc_nxt = sneg_r ? (~quo_w + SUM_W'(1)) : quo_w;

  // Sequencer: next state, handshakes and unit operands.
  always_comb begin
    state_nxt = state_r;
    in_ready = 1'b0;
    load_out = 1'b0;
    div_start = 1'b0;
    div_dvd = '0;
    div_den = '0;
    mula_start = 1'b0;
    mula_a = '0;
    mula_b = '0;
    mulb_start = 1'b0;
    mulb_a = '0;
    mulb_b = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = (in_r.operation == OP_CLEAR) ? ST_DONE : ST_BAND;
      end
      ST_BAND: begin
        state_nxt = band_out ? ST_DIFF : ST_DONE;
      end
      ST_DIFF:  state_nxt = ST_ABS;
      ST_ABS:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_GO1;
      ST_GO1: begin
        // Rate division and the trapezoid product run side by side.
        div_start = 1'b1;
        div_dvd = dvd_r;
        div_den = ms_eff;
        mulb_start = 1'b1;
        mulb_a = MUL_A_W'(smag_r);
        mulb_b = MUL_B_W'(ms_eff);
        state_nxt = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (!div_busy && !mulb_busy) begin
          state_nxt = ST_GO2;
        end
      end
      ST_GO2: begin
        // Trapezoid division and the proportional product.
        div_start = 1'b1;
        div_dvd = mulb_prod[DIV_N_W-1:0];
        div_den = TRAP_DIV;
        mula_start = 1'b1;
        mula_a = MUL_A_W'(emag_r);
        mula_b = abs32(gain_p_r);
        state_nxt = ST_WAIT2;
      end
      ST_WAIT2: begin
        if (!div_busy && !mula_busy) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC:    state_nxt = ST_ACCSUM;
      ST_ACCSUM: state_nxt = ST_CLAMPI;
      ST_CLAMPI: state_nxt = ST_GO3;
      ST_GO3: begin
        // Derivative and integral products.
        mula_start = 1'b1;
        mula_a = rmag_r;
        mula_b = abs32(gain_d_r);
        mulb_start = 1'b1;
        mulb_a = MUL_A_W'(abs32(integral_r));
        mulb_b = abs32(gain_i_r);
        state_nxt = ST_WAIT3;
      end
      ST_WAIT3: begin
        if (!mula_busy && !mulb_busy) begin
          state_nxt = ST_TERMS;
        end
      end
      ST_TERMS:  state_nxt = ST_SUM1;
      ST_SUM1:   state_nxt = ST_SUM2;
      ST_SUM2:   state_nxt = ST_CLAMPD;
      ST_CLAMPD: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes, always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      dead_band_r <= '0;
      imin_r <= DATA_MIN;
      imax_r <= DATA_MAX;
      dmin_r <= DATA_MIN;
      dmax_r <= DATA_MAX;
    end else if (cfg_valid) begin
      unique case (cfg_sel_t'(cfg_index))
        CFG_GAIN_P:       gain_p_r <= cfg_data;
        CFG_GAIN_I:       gain_i_r <= cfg_data;
        CFG_GAIN_D:       gain_d_r <= cfg_data;
        CFG_DEAD_BAND:    dead_band_r <= cfg_data[BAND_W-1:0];
        CFG_INTEGRAL_MIN: imin_r <= cfg_data;
        CFG_INTEGRAL_MAX: imax_r <= cfg_data;
        CFG_DRIVE_MIN:    dmin_r <= cfg_data;
        CFG_DRIVE_MAX:    dmax_r <= cfg_data;
        default:          gain_p_r <= gain_p_r;
      endcase
    end
  end

  // Controller history: cleared by a clear word, except the derivative's last
  // error; updated when the integral is clamped (at the band test when skipped).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= 1'b0;
      pde_r <= '0;
      pse_r <= '0;
      integral_r <= '0;
    end else begin
      if (state_r == ST_PREP && in_r.operation == OP_CLEAR) begin
        hist_r <= 1'b0;
        pse_r <= '0;
        integral_r <= '0;
      end
      if (state_r == ST_BAND && !band_out) begin
        hist_r <= 1'b1;
        pse_r <= err_sat;
      end
      if (state_r == ST_CLAMPI) begin
        hist_r <= 1'b1;
        pse_r <= err_r;
        pde_r <= err_r;
        integral_r <= clamp_w(acc_r, imin_r, imax_r);
      end
    end
  end

  // Sample datapath, one step per state.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_word;
    end
    unique case (state_r)
      ST_PREP: begin
        raw_r <= {in_r.target[DATA_W-1], in_r.target}
                 - {in_r.measurement[DATA_W-1], in_r.measurement};
        if (in_r.operation == OP_CLEAR) begin
          res_drive_r <= '0;
          res_active_r <= 1'b0;
        end
      end
      ST_BAND: begin
        err_r <= err_sat;
        if (!band_out) begin
          res_drive_r <= clamp_w('0, dmin_r, dmax_r);
          res_active_r <= 1'b0;
        end
      end
      ST_DIFF: begin
        diff_r <= DIFF_W'(err_r) - DIFF_W'(pde_r);
        sum_r <= DIFF_W'(err_r) + DIFF_W'(pse_r);
      end
      ST_ABS: begin
        dmag_r <= abs33(diff_r);
        dneg_r <= diff_r[DIFF_W-1];
        smag_r <= abs33(sum_r);
        sneg_r <= sum_r[DIFF_W-1];
        emag_r <= abs32(err_r);
        eneg_r <= err_r[DATA_W-1];
      end
      ST_SCALE: begin
        dvd_r <= DIV_N_W'(scaled);
      end
      ST_GO2: begin
        // The rate quotient is still held; the divider restarts next edge.
        rmag_r <= div_quo[MUL_A_W-1:0];
      end
      ST_ACC: begin
        p_r <= to_term(mula_prod, eneg_r ^ gain_p_r[DATA_W-1]);
        inc_r <= inc_nxt;
      end
      ST_ACCSUM: begin
        acc_r <= SUM_W'(integral_r) + inc_r;
      end
      ST_TERMS: begin
        d_r <= to_term(mula_prod, dneg_r ^ gain_d_r[DATA_W-1]);
        i_r <= to_term(mulb_prod, integral_r[DATA_W-1] ^ gain_i_r[DATA_W-1]);
      end
      ST_SUM1: begin
        s_r <= SUM_W'(p_r) + SUM_W'(i_r);
      end
      ST_SUM2: begin
        s_r <= s_r + SUM_W'(d_r);
      end
      ST_CLAMPD: begin
        res_drive_r <= clamp_w(s_r, dmin_r, dmax_r);
        res_active_r <= 1'b1;
      end
      default: begin
        res_active_r <= res_active_r;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.drive <= res_drive_r;
      out_r.active <= res_active_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word = out_r;

  // Serial units.
  pdc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .dvd    (div_dvd),
    .den    (div_den),
    .busy   (div_busy),
    .quo    (div_quo)
  );

  pdc_mul u_mula (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mula_start),
    .mcand  (mula_a),
    .mplier (mula_b),
    .busy   (mula_busy),
    .prod   (mula_prod)
  );

  pdc_mul u_mulb (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mulb_start),
    .mcand  (mulb_a),
    .mplier (mulb_b),
    .busy   (mulb_busy),
    .prod   (mulb_prod)
  );

`ifndef SYNTH
  // No serial unit runs while the block waits for a word.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !(div_busy || mula_busy || mulb_busy))
    else $error("serial unit busy while idle");

  // Each unit runs only in the wait states that consume its result.
  a_div_window: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == ST_WAIT1 || state_r == ST_WAIT2))
    else $error("divider running outside its wait states");

  a_mula_window: assert property (@(posedge clk) disable iff (!rst_n)
    mula_busy |-> (state_r == ST_WAIT2 || state_r == ST_WAIT3))
    else $error("multiplier A running outside its wait states");

  a_mulb_window: assert property (@(posedge clk) disable iff (!rst_n)
    mulb_busy |-> (state_r == ST_WAIT1 || state_r == ST_WAIT3))
    else $error("multiplier B running outside its wait states");

  // A new result only appears out of the final state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word loaded outside the final state");
`endif

endmodule

/* hw/rtl/pdc_mul.sv */
// ----------------------------------------------------------------------------
// pdc_mul: serial unsigned multiplier
// Shift-and-add multiplier that retires one multiplier bit per cycle. The
// product stays in place after the last step until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdc_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pdc_pkg::MUL_A_W-1:0]   mcand,
  input  logic [pdc_pkg::MUL_B_W-1:0]   mplier,
  output logic                          busy,
  output logic [pdc_pkg::MUL_P_W-1:0]   prod
);
  import pdc_pkg::*;

  logic [MUL_A_W-1:0]   mcand_r;
  logic [MUL_A_W-1:0]   hi_r, hi_nxt;
  logic [MUL_B_W-1:0]   lo_r, lo_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic [MUL_A_W:0]     psum;

  // One step: add the multiplicand when the low bit is set, then shift the
  // whole partial product right by one.
  always_comb begin
    psum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (start) begin
      hi_nxt = '0;
      lo_nxt = mplier;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      hi_nxt = psum[MUL_A_W:1];
      lo_nxt = {psum[0], lo_r[MUL_B_W-1:1]};
      cnt_nxt = cnt_r + MUL_CNT_W'(1);
      if (cnt_r == MUL_CNT_W'(MUL_B_W - 1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Operand and partial product.
  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    if (start) begin
      mcand_r <= mcand;
    end
  end

  assign busy = run_r;
  assign prod = {hi_r, lo_r};

endmodule

/* hw/rtl/pdc_div.sv */
// ----------------------------------------------------------------------------
// pdc_div: serial unsigned divider
// Restoring divider that shifts in one dividend bit and produces one quotient
// bit per cycle. The quotient stays in place until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pdc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pdc_pkg::DIV_N_W-1:0]   dvd,
  input  logic [pdc_pkg::DIV_D_W-1:0]   den,
  output logic                          busy,
  output logic [pdc_pkg::DIV_N_W-1:0]   quo
);
  import pdc_pkg::*;

  logic [DIV_D_W-1:0]   den_r;
  logic [DIV_N_W-1:0]   quo_r, quo_nxt;
  logic [DIV_D_W-1:0]   rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic [DIV_D_W:0]     trial;
  logic [DIV_D_W:0]     diff;

  // One step: bring down the next dividend bit and subtract the divisor if
  // it fits. A borrow shows in the top bit of the difference.
  always_comb begin
    trial = {rem_r, quo_r[DIV_N_W-1]};
    diff = trial - {1'b0, den_r};
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    if (start) begin
      quo_nxt = dvd;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (diff[DIV_D_W]) begin
        rem_nxt = trial[DIV_D_W-1:0];
        quo_nxt = {quo_r[DIV_N_W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[DIV_D_W-1:0];
        quo_nxt = {quo_r[DIV_N_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_N_W - 1)) begin
        run_nxt = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Divisor, remainder and quotient.
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = run_r;
  assign quo = quo_r;

endmodule
